### hw/rtl/ptsd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptsd_pkg
// Widths, types and helpers for the point to segment distance pipeline.
// ----------------------------------------------------------------------------
package ptsd_pkg;

    localparam int CoordW   = 32;
    localparam int VecW     = CoordW + 1;
    localparam int ProdW    = 2 * VecW;
    localparam int DotW     = ProdW + 2;
    localparam int C2W      = ProdW;
    localparam int MagW     = DotW - 1;
    localparam int FracW    = 16;
    localparam int NumW     = MagW + FracW;
    localparam int QW       = CoordW + 1;
    localparam int DivSteps = QW;
    localparam int DivW     = C2W + DivSteps + 1;
    localparam int TProdW   = VecW + CoordW;
    localparam int OffW     = TProdW - FracW;
    localparam int NrW      = OffW + 1;
    localparam int AdW      = NrW + 1;
    localparam int LoW      = 25;
    localparam int HiW      = AdW - LoW;
    localparam int SqW      = 2 * AdW;
    localparam int DsqW     = SqW + 2;
    localparam int RootW    = 50;
    localparam int DistW    = 33;
    localparam int CfgIdxW  = 3;

    typedef enum logic [CfgIdxW-1:0] {
        REG_START_X = 3'd0,
        REG_START_Y = 3'd1,
        REG_START_Z = 3'd2,
        REG_END_X   = 3'd3,
        REG_END_Y   = 3'd4,
        REG_END_Z   = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic                     op;
        logic signed [CoordW-1:0] px;
        logic signed [CoordW-1:0] py;
        logic signed [CoordW-1:0] pz;
        logic                     negc;
        logic                     sat;
        logic                     degen;
        logic [C2W-1:0]           c2;
        logic [NumW-1:0]          rem;
        logic [QW-1:0]            q;
    } div_item_t;

    typedef struct packed {
        logic signed [CoordW-1:0] t;
        logic signed [NrW-1:0]    nx;
        logic signed [NrW-1:0]    ny;
        logic signed [NrW-1:0]    nz;
        logic                     degen;
        logic [DsqW-1:0]          rem;
        logic [RootW-1:0]         root;
    } root_item_t;

    function automatic logic signed [CoordW-1:0] sat32(input logic signed [NrW-1:0] x);
        logic signed [NrW-1:0] hi_lim;
        logic signed [NrW-1:0] lo_lim;
        hi_lim = NrW'(signed'({1'b0, {(CoordW-1){1'b1}}}));
        lo_lim = NrW'(signed'({1'b1, {(CoordW-1){1'b0}}}));
        if (x > hi_lim) begin
            return {1'b0, {(CoordW-1){1'b1}}};
        end else if (x < lo_lim) begin
            return {1'b1, {(CoordW-1){1'b0}}};
        end
        return x[CoordW-1:0];
    endfunction

endpackage
`default_nettype wire

### hw/rtl/point_to_segment_distance.sv
`default_nettype none
// ----------------------------------------------------------------------------
// point_to_segment_distance
// Projects a query point onto a configured 3D line or segment and returns
// the parameter, the nearest point and the distance, in Q16.16.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  op, point x/y/z
// m_        out        m_valid / m_ready  distance, param, near x/y/z, degenerate
// cfg_      in         cfg_we             cfg_index, cfg_data
//
// One request enters per cycle while no result waits on m_ready.
// The pipeline includes the 33-stage restoring divider and the 50-stage
// square root, one result bit per stage.
// Reset clears the configuration registers and all valid bits.
// When a result waits on m_ready the whole pipeline holds.
// ----------------------------------------------------------------------------
module point_to_segment_distance
    import ptsd_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_we,
    input  wire logic [CfgIdxW-1:0]       cfg_index,
    input  wire logic [CoordW-1:0]        cfg_data,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic                     s_op,
    input  wire logic signed [CoordW-1:0] s_point_x,
    input  wire logic signed [CoordW-1:0] s_point_y,
    input  wire logic signed [CoordW-1:0] s_point_z,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [DistW-1:0]              m_distance,
    output logic signed [CoordW-1:0]      m_param,
    output logic signed [CoordW-1:0]      m_near_x,
    output logic signed [CoordW-1:0]      m_near_y,
    output logic signed [CoordW-1:0]      m_near_z,
    output logic                          m_degenerate
);

    logic signed [CoordW-1:0] start_reg [3];
    logic signed [CoordW-1:0] end_reg [3];
    logic signed [VecW-1:0]   vec [3];
    logic                     en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                start_reg[i] <= '0;
                end_reg[i]   <= '0;
            end
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_START_X: start_reg[0] <= cfg_data;
                REG_START_Y: start_reg[1] <= cfg_data;
                REG_START_Z: start_reg[2] <= cfg_data;
                REG_END_X:   end_reg[0]   <= cfg_data;
                REG_END_Y:   end_reg[1]   <= cfg_data;
                REG_END_Z:   end_reg[2]   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            vec[i] = VecW'(end_reg[i]) - VecW'(start_reg[i]);
        end
    end

    logic out_vld_reg;
    assign en      = !out_vld_reg || m_ready;
    assign s_ready = en;

    // Stage A: offset of the point from the start.
    logic                     a_vld_reg;
    logic                     a_op_reg;
    logic signed [CoordW-1:0] a_p_reg [3];
    logic signed [VecW-1:0]   a_w_reg [3];
    logic signed [CoordW-1:0] in_p [3];

    assign in_p[0] = s_point_x;
    assign in_p[1] = s_point_y;
    assign in_p[2] = s_point_z;

    always_ff @(posedge aclk) begin
        if (en) begin
            a_op_reg <= s_op;
            for (int i = 0; i < 3; i++) begin
                a_p_reg[i] <= in_p[i];
                a_w_reg[i] <= VecW'(in_p[i]) - VecW'(start_reg[i]);
            end
        end
    end

    // Stage B: products.
    logic                     b_vld_reg;
    logic                     b_op_reg;
    logic signed [CoordW-1:0] b_p_reg [3];
    logic signed [ProdW-1:0]  b_pr_reg [3];
    logic signed [ProdW-1:0]  b_vv_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            b_op_reg <= a_op_reg;
            for (int i = 0; i < 3; i++) begin
                b_p_reg[i]  <= a_p_reg[i];
                b_pr_reg[i] <= vec[i] * a_w_reg[i];
                b_vv_reg[i] <= vec[i] * vec[i];
            end
        end
    end

    // Stage C: dot products.
    logic                     c_vld_reg;
    logic                     c_op_reg;
    logic signed [CoordW-1:0] c_p_reg [3];
    logic signed [DotW-1:0]   c_dot_reg;
    logic [C2W-1:0]           c_c2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            c_op_reg  <= b_op_reg;
            for (int i = 0; i < 3; i++) begin
                c_p_reg[i] <= b_p_reg[i];
            end
            c_dot_reg <= DotW'(b_pr_reg[0]) + DotW'(b_pr_reg[1]) + DotW'(b_pr_reg[2]);
            c_c2_reg  <= C2W'(b_vv_reg[0]) + C2W'(b_vv_reg[1]) + C2W'(b_vv_reg[2]);
        end
    end

    // Stage D: magnitude, overflow check and dividend.
    logic            d_vld_reg;
    div_item_t       d_reg;
    div_item_t       d_next;
    logic [MagW-1:0] d_mc;

    always_comb begin
        d_mc         = c_dot_reg[DotW-1] ? MagW'(-c_dot_reg) : MagW'(c_dot_reg);
        d_next.op    = c_op_reg;
        d_next.px    = c_p_reg[0];
        d_next.py    = c_p_reg[1];
        d_next.pz    = c_p_reg[2];
        d_next.negc  = c_dot_reg[DotW-1];
        d_next.sat   = DivW'(d_mc) >= (DivW'(c_c2_reg) << (FracW + 1));
        d_next.degen = (c_c2_reg == '0);
        d_next.c2    = c_c2_reg;
        d_next.rem   = {d_mc, {FracW{1'b0}}};
        d_next.q     = '0;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    // Divider: one quotient bit per stage.
    div_item_t           div_in [DivSteps];
    div_item_t           div_next [DivSteps];
    div_item_t           div_reg [DivSteps];
    logic [DivSteps-1:0] div_vld_reg;

    for (genvar k = 0; k < DivSteps; k++) begin : g_div
        localparam int Bit = DivSteps - 1 - k;
        logic [DivW-1:0] dsh;
        if (k == 0) begin : g_first
            assign div_in[k] = d_reg;
        end else begin : g_rest
            assign div_in[k] = div_reg[k-1];
        end
        always_comb begin
            div_next[k] = div_in[k];
            dsh         = DivW'(div_in[k].c2) << Bit;
            if (DivW'(div_in[k].rem) >= dsh) begin
                div_next[k].rem    = NumW'(DivW'(div_in[k].rem) - dsh);
                div_next[k].q[Bit] = 1'b1;
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                div_reg[k] <= div_next[k];
            end
        end
    end

    // Stage E: parameter with saturation, clamped to [0, 1] when op is set.
    div_item_t                div_last;
    logic                     e_vld_reg;
    logic signed [CoordW-1:0] e_p_reg [3];
    logic signed [CoordW-1:0] e_t_reg;
    logic signed [CoordW-1:0] e_t_next;
    logic                     e_degen_reg;

    assign div_last = div_reg[DivSteps-1];

    always_comb begin
        if (div_last.degen) begin
            e_t_next = '0;
        end else if (div_last.negc) begin
            if (div_last.sat || div_last.q > QW'({1'b1, {(CoordW-1){1'b0}}})) begin
                e_t_next = {1'b1, {(CoordW-1){1'b0}}};
            end else begin
                e_t_next = -signed'(div_last.q[CoordW-1:0]);
            end
        end else begin
            if (div_last.sat || div_last.q > QW'({1'b0, {(CoordW-1){1'b1}}})) begin
                e_t_next = {1'b0, {(CoordW-1){1'b1}}};
            end else begin
                e_t_next = div_last.q[CoordW-1:0];
            end
        end
        if (div_last.op) begin
            if (e_t_next < 0) begin
                e_t_next = '0;
            end else if (e_t_next > CoordW'(1 << FracW)) begin
                e_t_next = CoordW'(1 << FracW);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e_p_reg[0]  <= div_last.px;
            e_p_reg[1]  <= div_last.py;
            e_p_reg[2]  <= div_last.pz;
            e_t_reg     <= e_t_next;
            e_degen_reg <= div_last.degen;
        end
    end

    // Stage F: direction times parameter.
    logic                     f_vld_reg;
    logic signed [CoordW-1:0] f_p_reg [3];
    logic signed [CoordW-1:0] f_t_reg;
    logic                     f_degen_reg;
    logic signed [TProdW-1:0] f_prod_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            f_t_reg     <= e_t_reg;
            f_degen_reg <= e_degen_reg;
            for (int i = 0; i < 3; i++) begin
                f_p_reg[i]    <= e_p_reg[i];
                f_prod_reg[i] <= vec[i] * e_t_reg;
            end
        end
    end

    // Stage G: nearest point, offsets rounded toward minus infinity.
    logic                     g_vld_reg;
    logic signed [CoordW-1:0] g_p_reg [3];
    logic signed [CoordW-1:0] g_t_reg;
    logic                     g_degen_reg;
    logic signed [NrW-1:0]    g_nr_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            g_t_reg     <= f_t_reg;
            g_degen_reg <= f_degen_reg;
            for (int i = 0; i < 3; i++) begin
                g_p_reg[i]  <= f_p_reg[i];
                g_nr_reg[i] <= NrW'(start_reg[i])
                             + NrW'(signed'(f_prod_reg[i][TProdW-1:FracW]));
            end
        end
    end

    // Stage H: absolute differences.
    logic                     h_vld_reg;
    logic signed [CoordW-1:0] h_t_reg;
    logic                     h_degen_reg;
    logic signed [NrW-1:0]    h_nr_reg [3];
    logic [AdW-1:0]           h_ad_reg [3];
    logic signed [AdW-1:0]    h_d [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            h_d[i] = AdW'(g_p_reg[i]) - AdW'(g_nr_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            h_t_reg     <= g_t_reg;
            h_degen_reg <= g_degen_reg;
            for (int i = 0; i < 3; i++) begin
                h_nr_reg[i] <= g_nr_reg[i];
                h_ad_reg[i] <= h_d[i][AdW-1] ? AdW'(-h_d[i]) : AdW'(h_d[i]);
            end
        end
    end

    // Stage I: partial products of the squares.
    logic                     i_vld_reg;
    logic signed [CoordW-1:0] i_t_reg;
    logic                     i_degen_reg;
    logic signed [NrW-1:0]    i_nr_reg [3];
    logic [2*HiW-1:0]         i_hh_reg [3];
    logic [HiW+LoW-1:0]       i_hl_reg [3];
    logic [2*LoW-1:0]         i_ll_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            i_t_reg     <= h_t_reg;
            i_degen_reg <= h_degen_reg;
            for (int i = 0; i < 3; i++) begin
                i_nr_reg[i] <= h_nr_reg[i];
                i_hh_reg[i] <= h_ad_reg[i][AdW-1:LoW] * h_ad_reg[i][AdW-1:LoW];
                i_hl_reg[i] <= h_ad_reg[i][AdW-1:LoW] * h_ad_reg[i][LoW-1:0];
                i_ll_reg[i] <= h_ad_reg[i][LoW-1:0] * h_ad_reg[i][LoW-1:0];
            end
        end
    end

    // Stage J: squares.
    logic                     j_vld_reg;
    logic signed [CoordW-1:0] j_t_reg;
    logic                     j_degen_reg;
    logic signed [NrW-1:0]    j_nr_reg [3];
    logic [SqW-1:0]           j_sq_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            j_t_reg     <= i_t_reg;
            j_degen_reg <= i_degen_reg;
            for (int i = 0; i < 3; i++) begin
                j_nr_reg[i] <= i_nr_reg[i];
                j_sq_reg[i] <= (SqW'(i_hh_reg[i]) << (2 * LoW))
                             + (SqW'(i_hl_reg[i]) << (LoW + 1))
                             + SqW'(i_ll_reg[i]);
            end
        end
    end

    // Stage K: squared distance.
    logic       k_vld_reg;
    root_item_t k_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            k_reg.t     <= j_t_reg;
            k_reg.nx    <= j_nr_reg[0];
            k_reg.ny    <= j_nr_reg[1];
            k_reg.nz    <= j_nr_reg[2];
            k_reg.degen <= j_degen_reg;
            k_reg.rem   <= DsqW'(j_sq_reg[0]) + DsqW'(j_sq_reg[1]) + DsqW'(j_sq_reg[2]);
            k_reg.root  <= '0;
        end
    end

    // Square root: one result bit per stage.
    root_item_t       root_in [RootW];
    root_item_t       root_next [RootW];
    root_item_t       root_reg [RootW];
    logic [RootW-1:0] root_vld_reg;

    for (genvar k = 0; k < RootW; k++) begin : g_root
        localparam int Bit = RootW - 1 - k;
        logic [DsqW-1:0] trial;
        if (k == 0) begin : g_first
            assign root_in[k] = k_reg;
        end else begin : g_rest
            assign root_in[k] = root_reg[k-1];
        end
        always_comb begin
            root_next[k] = root_in[k];
            trial        = (DsqW'(root_in[k].root) << (Bit + 1)) + (DsqW'(1) << (2 * Bit));
            if (root_in[k].rem >= trial) begin
                root_next[k].rem       = root_in[k].rem - trial;
                root_next[k].root[Bit] = 1'b1;
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                root_reg[k] <= root_next[k];
            end
        end
    end

    // Output register.
    root_item_t root_last;
    assign root_last = root_reg[RootW-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            m_distance   <= (root_last.root > RootW'({DistW{1'b1}})) ?
                            {DistW{1'b1}} : root_last.root[DistW-1:0];
            m_param      <= root_last.t;
            m_near_x     <= sat32(root_last.nx);
            m_near_y     <= sat32(root_last.ny);
            m_near_z     <= sat32(root_last.nz);
            m_degenerate <= root_last.degen;
        end
    end

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg    <= 1'b0;
            b_vld_reg    <= 1'b0;
            c_vld_reg    <= 1'b0;
            d_vld_reg    <= 1'b0;
            div_vld_reg  <= '0;
            e_vld_reg    <= 1'b0;
            f_vld_reg    <= 1'b0;
            g_vld_reg    <= 1'b0;
            h_vld_reg    <= 1'b0;
            i_vld_reg    <= 1'b0;
            j_vld_reg    <= 1'b0;
            k_vld_reg    <= 1'b0;
            root_vld_reg <= '0;
            out_vld_reg  <= 1'b0;
        end else if (en) begin
            a_vld_reg    <= s_valid;
            b_vld_reg    <= a_vld_reg;
            c_vld_reg    <= b_vld_reg;
            d_vld_reg    <= c_vld_reg;
            div_vld_reg  <= {div_vld_reg[DivSteps-2:0], d_vld_reg};
            e_vld_reg    <= div_vld_reg[DivSteps-1];
            f_vld_reg    <= e_vld_reg;
            g_vld_reg    <= f_vld_reg;
            h_vld_reg    <= g_vld_reg;
            i_vld_reg    <= h_vld_reg;
            j_vld_reg    <= i_vld_reg;
            k_vld_reg    <= j_vld_reg;
            root_vld_reg <= {root_vld_reg[RootW-2:0], k_vld_reg};
            out_vld_reg  <= root_vld_reg[RootW-1];
        end
    end

    assign m_valid = out_vld_reg;

endmodule
`default_nettype wire
